@@ rtl/mpk_pkg.sv @@
// Shared constants, types and helpers for the morse pattern keyer.
// No dependencies. Imported by morse_pattern_keyer.
`timescale 1ns / 1ps

package mpk_pkg;

    localparam int PATTERN_BITS = 8;
    localparam int PAT_IN_W     = 8;
    localparam int WPM_W        = 7;
    localparam int DOT_W        = 11;
    localparam int DUR_W        = 14;
    localparam int DUR_BYTES_W  = ((DUR_W + 7) / 8) * 8;
    localparam int DIV_CNT_W    = $clog2(DOT_W);

    localparam logic [DOT_W-1:0] MS_PER_DOT_AT_1WPM = DOT_W'(1200);
    localparam logic [WPM_W-1:0] WPM_RESET          = WPM_W'(20);
    localparam logic [DOT_W-1:0] DOT_RESET          = DOT_W'(60);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_MARK,
        ST_SPACE,
        ST_END,
        ST_WORD
    } state_t;

    typedef enum logic [1:0] {
        SEG_DOT,
        SEG_DASH,
        SEG_CHAR_GAP,
        SEG_WORD_GAP
    } seg_kind_t;

    typedef logic [PATTERN_BITS-1:0] pattern_t;

    // mask the input field to the pattern width, zero above the field
    function automatic pattern_t mask_pattern(input logic [PAT_IN_W-1:0] p);
        pattern_t r;
        r = '0;
        for (int i = 0; i < PATTERN_BITS; i++) begin
            if (i < PAT_IN_W) begin
                r[i] = p[i];
            end
        end
        return r;
    endfunction

endpackage

@@ rtl/morse_pattern_keyer.sv @@
// Morse pattern keyer top level: speed register, bit-serial dot divider,
// pattern shift register, segment sequencer and output register. Uses mpk_pkg.
`timescale 1ns / 1ps

// Each input transaction is a pattern (LSB first, 1 = dah, 0 = dit, topmost set
// bit is the sentinel) or, with tuser set, a word space. A pattern with n
// elements gives 2n+1 output transactions: mark, one-dot space per element,
// then a two-dot gap flagged with tlast; a word space gives one seven-dot gap.
// The sequencer emits one segment per cycle while m_tready stays high; a new
// item is taken as soon as the last segment sits in the output register.
// Writing the speed starts a restoring division of 1200 by the speed, one
// quotient bit per cycle, which holds s_tready low until the quotient is
// complete. A speed of 0 is taken as 1.
module morse_pattern_keyer (
    input  logic                          aclk,
    input  logic                          aresetn,
    // speed register write
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [mpk_pkg::WPM_W-1:0]     cfg_data,       // words_per_minute
    // input items
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [mpk_pkg::PAT_IN_W-1:0]  s_tdata,        // symbol_pattern
    input  logic                          s_tuser,        // is_space
    // key segments
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [mpk_pkg::DUR_BYTES_W-1:0] m_tdata,      // duration_ms, zero pad
    output logic                          m_tuser,        // key_on
    output logic                          m_tlast         // last_segment
);
    import mpk_pkg::*;

    state_t                 state_reg, state_next;
    pattern_t               pat_reg, pat_next;
    logic [DOT_W-1:0]       dot_reg, dot_next;
    logic [WPM_W-1:0]       divisor_reg, divisor_next;
    logic [WPM_W-1:0]       rem_reg, rem_next;
    logic [DOT_W-1:0]       quo_reg, quo_next;
    logic [DIV_CNT_W-1:0]   div_cnt_reg, div_cnt_next;
    logic                   m_valid_reg, m_valid_next;
    logic [DUR_W-1:0]       m_dur_reg, m_dur_next;
    logic                   m_on_reg, m_on_next;
    logic                   m_last_reg, m_last_next;

    logic                   out_free;
    logic                   in_acc;
    logic                   cfg_acc;
    logic                   emit;
    logic                   seg_on;
    logic                   seg_last;
    seg_kind_t              seg_kind;
    logic [WPM_W:0]         trial;
    logic                   q_bit;
    logic [DUR_W-1:0]       dot_w;
    logic [DUR_W-1:0]       seg_dur;
    pattern_t               pat_shift;
    pattern_t               in_pat;
    logic                   more_elems;

    assign out_free   = !m_valid_reg || m_tready;
    assign cfg_acc    = cfg_valid && cfg_ready;
    assign in_acc     = s_tvalid && s_tready;
    assign in_pat     = mask_pattern(s_tdata);
    assign pat_shift  = pat_reg >> 1;
    assign more_elems = |pat_shift[PATTERN_BITS-1:1];

    // restoring division step
    assign trial = {rem_reg, quo_reg[DOT_W-1]} - {1'b0, divisor_reg};
    assign q_bit = !trial[WPM_W];

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (cfg_acc) begin
                    state_next = ST_DIV;
                end else if (in_acc) begin
                    if (s_tuser) begin
                        state_next = ST_WORD;
                    end else if (|in_pat[PATTERN_BITS-1:1]) begin
                        state_next = ST_MARK;
                    end else begin
                        state_next = ST_END;
                    end
                end
            end
            ST_DIV: begin
                if (div_cnt_reg == '0) begin
                    state_next = ST_IDLE;
                end
            end
            ST_MARK: begin
                if (out_free) begin
                    state_next = ST_SPACE;
                end
            end
            ST_SPACE: begin
                if (out_free) begin
                    state_next = more_elems ? ST_MARK : ST_END;
                end
            end
            ST_END, ST_WORD: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb begin
        cfg_ready = 1'b0;
        s_tready  = 1'b0;
        emit      = 1'b0;
        seg_on    = 1'b0;
        seg_last  = 1'b0;
        seg_kind  = SEG_DOT;
        case (state_reg)
            ST_IDLE: begin
                cfg_ready = 1'b1;
                s_tready  = !cfg_valid;
            end
            ST_DIV: begin
            end
            ST_MARK: begin
                emit     = out_free;
                seg_on   = 1'b1;
                seg_kind = pat_reg[0] ? SEG_DASH : SEG_DOT;
            end
            ST_SPACE: begin
                emit = out_free;
            end
            ST_END: begin
                emit     = out_free;
                seg_last = 1'b1;
                seg_kind = SEG_CHAR_GAP;
            end
            ST_WORD: begin
                emit     = out_free;
                seg_last = 1'b1;
                seg_kind = SEG_WORD_GAP;
            end
            default: begin
            end
        endcase
    end

    // segment length from the dot length
    assign dot_w = DUR_W'(dot_reg);
    always_comb begin
        case (seg_kind)
            SEG_DOT:      seg_dur = dot_w;
            SEG_DASH:     seg_dur = dot_w + (dot_w << 1);
            SEG_CHAR_GAP: seg_dur = dot_w << 1;
            SEG_WORD_GAP: seg_dur = (dot_w << 3) - dot_w;
            default:      seg_dur = dot_w;
        endcase
    end

    // datapath next values
    always_comb begin
        pat_next     = pat_reg;
        dot_next     = dot_reg;
        divisor_next = divisor_reg;
        rem_next     = rem_reg;
        quo_next     = quo_reg;
        div_cnt_next = div_cnt_reg;
        if (cfg_acc) begin
            divisor_next = (cfg_data == '0) ? WPM_W'(1) : cfg_data;
            rem_next     = '0;
            quo_next     = MS_PER_DOT_AT_1WPM;
            div_cnt_next = DIV_CNT_W'(DOT_W - 1);
        end else if (state_reg == ST_DIV) begin
            rem_next     = q_bit ? trial[WPM_W-1:0]
                                 : {rem_reg[WPM_W-2:0], quo_reg[DOT_W-1]};
            quo_next     = {quo_reg[DOT_W-2:0], q_bit};
            div_cnt_next = div_cnt_reg - DIV_CNT_W'(1);
            if (div_cnt_reg == '0) begin
                dot_next = {quo_reg[DOT_W-2:0], q_bit};
            end
        end
        if (in_acc) begin
            pat_next = in_pat;
        end else if (state_reg == ST_SPACE && out_free) begin
            pat_next = pat_shift;
        end
    end

    // output register
    always_comb begin
        m_valid_next = m_valid_reg;
        m_dur_next   = m_dur_reg;
        m_on_next    = m_on_reg;
        m_last_next  = m_last_reg;
        if (emit) begin
            m_valid_next = 1'b1;
            m_dur_next   = seg_dur;
            m_on_next    = seg_on;
            m_last_next  = seg_last;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            dot_reg     <= DOT_RESET;
            divisor_reg <= WPM_RESET;
            div_cnt_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            dot_reg     <= dot_next;
            divisor_reg <= divisor_next;
            div_cnt_reg <= div_cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        pat_reg    <= pat_next;
        rem_reg    <= rem_next;
        quo_reg    <= quo_next;
        m_dur_reg  <= m_dur_next;
        m_on_reg   <= m_on_next;
        m_last_reg <= m_last_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = DUR_BYTES_W'(m_dur_reg);
    assign m_tuser  = m_on_reg;
    assign m_tlast  = m_last_reg;

    // an accepted item keeps the input closed on the following cycle
    a_item_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted on consecutive cycles");

    // a speed write holds off input while the divider runs
    a_div_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_valid && cfg_ready |=> !s_tready && !cfg_ready)
        else $error("input open during dot length division");

    // a key-down segment never closes a run
    a_mark_not_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> !m_tlast)
        else $error("key-down segment flagged as last");

endmodule
